[src/dq_pkg.sv]
// Shared types and constants for the double-ended queue core.
package dq_pkg;

    // Width of one stored word.
    localparam int WORD_W = 32;

    // Default number of entries in the ring.
    localparam int DEFAULT_CAPACITY = 16;

    // Width of the entry count reported with each result.
    localparam int COUNT_OUT_W = 5;

    // Operation requested by one input transaction.
    typedef enum logic [1:0] {
        KIND_PUSH_RIGHT = 2'd0,
        KIND_POP_RIGHT  = 2'd1,
        KIND_PUSH_LEFT  = 2'd2,
        KIND_POP_LEFT   = 2'd3
    } kind_t;

    // Outcome reported with each result.
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

endpackage

[src/dq_ram.sv]
// Single-port synchronous RAM that holds the queue words.
module dq_ram
    import dq_pkg::*;
#(
    parameter int DEPTH = DEFAULT_CAPACITY,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              en,
    input  logic              wr_en,
    input  logic [AW-1:0]     addr,
    input  logic [WORD_W-1:0] wr_data,
    output logic [WORD_W-1:0] rd_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    // Write on request; otherwise register the addressed word.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (wr_en)
            begin
                mem[addr] <= wr_data;
            end
            else
            begin
                rd_data_reg <= mem[addr];
            end
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[src/double_ended_queue_core.sv]
// Top level of the bounded double-ended queue core.
// An accepted transaction passes the pending stage and then the output register, where out_valid
// rises; a stalled output can hold it in either register.
// Throughput: one transaction per cycle unless the output stalls, set by the single RAM port
// used once per item. Pointer, count and RAM read data all register at the accept edge.
// Reset clears the left pointer, the count and all valid flags; RAM contents stay undefined.
module double_ended_queue_core
    import dq_pkg::*;
#(
    parameter int CAPACITY = DEFAULT_CAPACITY
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [1:0]               kind,
    input  logic signed [WORD_W-1:0] value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WORD_W-1:0] popped_value,
    output logic [1:0]               status,
    output logic [COUNT_OUT_W-1:0]   entry_count,
    output logic                     is_empty
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int SW   = CW + 1;
    localparam int EXTW = (CW > COUNT_OUT_W) ? CW : COUNT_OUT_W;

    localparam logic [IW-1:0] LAST_IDX = IW'(CAPACITY - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(CAPACITY);
    localparam logic [SW-1:0] CAP_SUM  = SW'(CAPACITY);

    // Ring state.
    logic [IW-1:0] left_reg, left_next;
    logic [CW-1:0] count_reg, count_next;

    // Stage waiting on RAM read data.
    logic          pend_valid_reg;
    logic          pend_pop_ok_reg;
    status_t       pend_status_reg;
    logic [CW-1:0] pend_count_reg;

    // Output register.
    logic                     out_valid_reg;
    logic signed [WORD_W-1:0] out_value_reg;
    status_t                  out_status_reg;
    logic [CW-1:0]            out_count_reg;

    logic              accept;
    logic              advance;
    kind_t             op;
    status_t           op_status;
    logic              op_pop_ok;
    logic              ram_wr;
    logic [IW-1:0]     ram_addr;
    logic [WORD_W-1:0] ram_rd_data;
    logic [SW-1:0]     right_sum;
    logic [SW-1:0]     right_off;
    logic [IW-1:0]     right_idx;
    logic [IW-1:0]     left_dec;
    logic [IW-1:0]     left_inc;
    logic [EXTW-1:0]   count_wide;

    // Handshake: the pending stage moves on whenever the output register frees up.
    assign advance  = pend_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !pend_valid_reg || advance;
    assign accept   = in_valid && in_ready;
    assign op       = kind_t'(kind);

    // Ring positions: right push slot or right pop slot, and the left neighbors.
    always_comb
    begin
        if (op == KIND_PUSH_RIGHT)
        begin
            right_off = {1'b0, count_reg};
        end
        else
        begin
            right_off = {1'b0, count_reg} - SW'(1);
        end
        right_sum = {{(SW - IW){1'b0}}, left_reg} + right_off;
        if (right_sum >= CAP_SUM)
        begin
            right_idx = IW'(right_sum - CAP_SUM);
        end
        else
        begin
            right_idx = IW'(right_sum);
        end
        left_dec = (left_reg == '0) ? LAST_IDX : left_reg - IW'(1);
        left_inc = (left_reg == LAST_IDX) ? '0 : left_reg + IW'(1);
    end

    // Decode the operation into a RAM access and the next ring state.
    always_comb
    begin
        left_next  = left_reg;
        count_next = count_reg;
        op_status  = STATUS_OK;
        op_pop_ok  = 1'b0;
        ram_wr     = 1'b0;
        ram_addr   = right_idx;
        unique case (op)
            KIND_PUSH_RIGHT:
            begin
                if (count_reg >= FULL_CNT)
                begin
                    op_status = STATUS_FULL;
                end
                else
                begin
                    ram_wr     = 1'b1;
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_PUSH_LEFT:
            begin
                ram_addr = left_dec;
                if (count_reg >= FULL_CNT)
                begin
                    op_status = STATUS_FULL;
                end
                else
                begin
                    ram_wr     = 1'b1;
                    left_next  = left_dec;
                    count_next = count_reg + CW'(1);
                end
            end
            KIND_POP_RIGHT:
            begin
                if (count_reg == '0)
                begin
                    op_status = STATUS_EMPTY;
                end
                else
                begin
                    op_pop_ok  = 1'b1;
                    count_next = count_reg - CW'(1);
                end
            end
            KIND_POP_LEFT:
            begin
                ram_addr = left_reg;
                if (count_reg == '0)
                begin
                    op_status = STATUS_EMPTY;
                end
                else
                begin
                    op_pop_ok  = 1'b1;
                    left_next  = left_inc;
                    count_next = count_reg - CW'(1);
                end
            end
        endcase
    end

    dq_ram #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_ram (
        .clk     (clk),
        .en      (accept),
        .wr_en   (ram_wr),
        .addr    (ram_addr),
        .wr_data (value),
        .rd_data (ram_rd_data)
    );

    // Ring state and pending-stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                left_reg  <= left_next;
                count_reg <= count_next;
            end
            if (accept)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // Pending-stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_pop_ok_reg <= op_pop_ok;
            pend_status_reg <= op_status;
            pend_count_reg  <= count_next;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload, with the RAM word only for a successful pop.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_value_reg  <= pend_pop_ok_reg ? ram_rd_data : '0;
            out_status_reg <= pend_status_reg;
            out_count_reg  <= pend_count_reg;
        end
    end

    assign count_wide   = EXTW'(out_count_reg);
    assign out_valid    = out_valid_reg;
    assign popped_value = out_value_reg;
    assign status       = out_status_reg;
    assign entry_count  = count_wide[COUNT_OUT_W-1:0];
    assign is_empty     = (out_count_reg == '0);

    // A refused operation never reports a word.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status_reg != STATUS_OK) |-> (popped_value == '0))
        else $error("refused operation reported a nonzero word");

    // The stored count never exceeds the capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("stored count exceeds capacity");

    // No new transaction is taken while a finished result is stalled behind another.
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input accepted while pipeline is stalled");

    // An accepted item yields a pending result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> pend_valid_reg)
        else $error("accepted transaction lost");

endmodule
